### design/dvc_pkg.sv
package dvc_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int COUNT_BITS  = 16;
  localparam int VALUE_BITS  = 32;
  localparam int OUT_BITS    = 16;

  localparam int IDX_BITS  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int USED_BITS = $clog2(TABLE_DEPTH + 1);
  localparam int SUM_BITS  = ((COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS) + 1;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [COUNT_BITS-1:0] count;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_UPDATE,
    S_INSERT,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

### design/dvc_ram.sv
module dvc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256,
  parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] addr,
  input  logic [WIDTH-1:0]     wdata,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### design/duplicate_value_counter_unit.sv
// Duplicate value counter.
// Item channel (value, last; item_valid / item_stall): one signed value per
// transaction, last marks the final value of a set. Result channel
// (top_value, top_duplicates, total_duplicates, overflow; result_valid /
// result_stall): one transaction per set, issued after the last value.
// Each value is looked up in a single-port table RAM holding the distinct
// values in order of first arrival, one entry read per cycle with the
// comparison in the cycle after its read. An item reads up to N entries,
// N being the number of distinct values stored so far (at most 256).
// A last item adds a scan of the table through the same port before the
// result is loaded into the output register.
// The output register lets the next set start while a result waits; only
// the following result waits in turn while result_stall is high.
// Synchronous reset empties the table (fill count to zero, overflow flag
// cleared) and drops any pending result. No clearing pass is needed: only
// entries below the fill count are read. Entries beyond table capacity are
// dropped and reported through overflow.
module duplicate_value_counter_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic signed [dvc_pkg::VALUE_BITS-1:0] value,
  input  logic                              last,
  input  logic                              item_valid,
  output logic                              item_stall,
  output logic signed [dvc_pkg::VALUE_BITS-1:0] top_value,
  output logic [dvc_pkg::OUT_BITS-1:0]      top_duplicates,
  output logic [dvc_pkg::OUT_BITS-1:0]      total_duplicates,
  output logic                              overflow,
  output logic                              result_valid,
  input  logic                              result_stall
);

  import dvc_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [OUT_BITS-1:0]   OUT_MAX   = '1;
  localparam logic [USED_BITS-1:0]  DEPTH_U   = USED_BITS'(TABLE_DEPTH);

  state_t state, state_next;

  logic [VALUE_BITS-1:0] cur_value;
  logic                  cur_last;
  logic [USED_BITS-1:0]  used;
  logic                  overflow_seen;
  logic [USED_BITS-1:0]  issue_idx;
  logic                  pend;
  logic [IDX_BITS-1:0]   pend_idx;
  logic [IDX_BITS-1:0]   hit_idx;
  logic [COUNT_BITS-1:0] hit_count;
  logic [COUNT_BITS-1:0] best;
  logic [VALUE_BITS-1:0] top;
  logic [OUT_BITS-1:0]   total;

  logic                  mem_we;
  logic [IDX_BITS-1:0]   mem_addr;
  entry_t                mem_wdata;
  logic [ENTRY_BITS-1:0] mem_rdata;
  entry_t                rd;

  logic                  hit;
  logic                  issue_more;
  logic                  load;
  logic [COUNT_BITS-1:0] count_inc;
  logic [SUM_BITS-1:0]   total_sum;
  logic [OUT_BITS-1:0]   total_sat;
  logic [SUM_BITS-1:0]   dup_ext;
  logic [OUT_BITS-1:0]   dup_sat;

  dvc_ram #(
    .WIDTH(ENTRY_BITS),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  assign rd         = entry_t'(mem_rdata);
  assign hit        = pend && (rd.value == cur_value);
  assign issue_more = issue_idx < used;
  assign item_stall = (state != S_IDLE);
  assign load       = (state == S_DONE) && (!result_valid || !result_stall);

  assign count_inc = (hit_count == COUNT_MAX) ? hit_count : hit_count + 1'b1;
  assign total_sum = SUM_BITS'(total) + SUM_BITS'(rd.count - 1'b1);
  assign total_sat = (total_sum > SUM_BITS'(OUT_MAX)) ? OUT_MAX : total_sum[OUT_BITS-1:0];
  assign dup_ext   = SUM_BITS'(best) - 1'b1;
  assign dup_sat   = (dup_ext > SUM_BITS'(OUT_MAX)) ? OUT_MAX : dup_ext[OUT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_addr   = issue_idx[IDX_BITS-1:0];
    mem_wdata  = '0;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          state_next = (used == '0) ? S_INSERT : S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (hit) begin
          state_next = S_UPDATE;
        end else if (!issue_more) begin
          state_next = S_INSERT;
        end
      end
      S_UPDATE: begin
        mem_we          = 1'b1;
        mem_addr        = hit_idx;
        mem_wdata.value = cur_value;
        mem_wdata.count = count_inc;
        state_next      = cur_last ? S_SCAN : S_IDLE;
      end
      S_INSERT: begin
        // drop the value when the table is full
        mem_we          = (used < DEPTH_U);
        mem_addr        = used[IDX_BITS-1:0];
        mem_wdata.value = cur_value;
        mem_wdata.count = COUNT_BITS'(1);
        state_next      = cur_last ? S_SCAN : S_IDLE;
      end
      S_SCAN: begin
        if (!issue_more) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used          <= '0;
      overflow_seen <= 1'b0;
      result_valid  <= 1'b0;
      pend          <= 1'b0;
      issue_idx     <= '0;
    end else begin
      if (result_valid && !result_stall && !load) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            cur_value <= value;
            cur_last  <= last;
            issue_idx <= '0;
            pend      <= 1'b0;
          end
        end
        S_SEARCH: begin
          // one read issued per cycle, compared on the following cycle
          if (issue_more) begin
            pend      <= 1'b1;
            pend_idx  <= issue_idx[IDX_BITS-1:0];
            issue_idx <= issue_idx + 1'b1;
          end else begin
            pend <= 1'b0;
          end
          hit_idx   <= pend_idx;
          hit_count <= rd.count;
        end
        S_UPDATE, S_INSERT: begin
          issue_idx <= '0;
          pend      <= 1'b0;
          best      <= '0;
          top       <= '0;
          total     <= '0;
          if (state == S_INSERT) begin
            if (used < DEPTH_U) begin
              used <= used + 1'b1;
            end else begin
              overflow_seen <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          if (issue_more) begin
            pend      <= 1'b1;
            issue_idx <= issue_idx + 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            // strict compare keeps the earliest entry on ties
            if (rd.count > best) begin
              best <= rd.count;
              top  <= rd.value;
            end
            total <= total_sat;
          end
        end
        S_DONE: begin
          if (load) begin
            top_value        <= top;
            top_duplicates   <= dup_sat;
            total_duplicates <= total;
            overflow         <= overflow_seen;
            result_valid     <= 1'b1;
            used             <= '0;
            overflow_seen    <= 1'b0;
          end
        end
        default: begin
          pend <= 1'b0;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= DEPTH_U)
    else $error("fill count beyond table depth");

  a_done_best: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> (best != '0))
    else $error("scan finished without a counted entry");

  a_update_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPDATE) |-> (USED_BITS'(hit_idx) < used))
    else $error("count update outside filled entries");

  a_load_clears: assert property (@(posedge clk) disable iff (rst)
    load |=> (used == '0) && !overflow_seen && result_valid)
    else $error("table not emptied after result load");

  a_dup_order: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (top_duplicates <= total_duplicates))
    else $error("top duplicates exceed total duplicates");
`endif

endmodule

### test/duplicate_tally_checker.sv
`timescale 1ns / 1ps

module duplicate_tally_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic signed [dvc_pkg::VALUE_BITS-1:0] value,
  input  logic                                  last,
  input  logic                                  item_valid,
  input  logic                                  item_stall,
  input  logic signed [dvc_pkg::VALUE_BITS-1:0] top_value,
  input  logic [dvc_pkg::OUT_BITS-1:0]          top_duplicates,
  input  logic [dvc_pkg::OUT_BITS-1:0]          total_duplicates,
  input  logic                                  overflow,
  input  logic                                  result_valid,
  input  logic                                  result_stall,
  output int unsigned                           mismatches,
  output int unsigned                           outstanding,
  output int unsigned                           sets_checked
);

  localparam longint unsigned OUT_MAX = (64'd1 << dvc_pkg::OUT_BITS) - 1;

  typedef struct packed {
    logic [dvc_pkg::VALUE_BITS-1:0] top;
    logic [dvc_pkg::OUT_BITS-1:0]   dups;
    logic [dvc_pkg::OUT_BITS-1:0]   total;
    logic                           spill;
  } summary_t;

  // distinct values of the open set, in order of first arrival
  logic [dvc_pkg::VALUE_BITS-1:0] seen_value [dvc_pkg::TABLE_DEPTH];
  logic [dvc_pkg::COUNT_BITS-1:0] seen_count [dvc_pkg::TABLE_DEPTH];
  int unsigned                    distinct_n = 0;
  logic                           spilled = 1'b0;

  summary_t predicted_summaries [$];

  initial begin
    mismatches   = 0;
    sets_checked = 0;
  end

  assign outstanding = predicted_summaries.size();

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected 0x%08h, actual 0x%08h", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : track
    summary_t                       want;
    logic [dvc_pkg::COUNT_BITS-1:0] best;
    longint unsigned                dup_sum;
    longint unsigned                top_dup;
    int                             hit;
    int unsigned                    i;
    if (rst) begin
      distinct_n = 0;
      spilled    = 1'b0;
      predicted_summaries.delete();
    end else begin
      // check the result side first: a result never belongs to a set closed this cycle
      if (result_valid && !result_stall) begin
        if (predicted_summaries.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual top 0x%08h dup %0d total %0d ovf %0b",
                   $time, top_value, top_duplicates, total_duplicates, overflow);
          mismatches++;
        end else begin
          want = predicted_summaries.pop_front();
          sets_checked++;
          compare_field("top_value", want.top, top_value);
          compare_field("top_duplicates", 32'(want.dups), 32'(top_duplicates));
          compare_field("total_duplicates", 32'(want.total), 32'(total_duplicates));
          compare_field("overflow", 32'(want.spill), 32'(overflow));
        end
      end

      if (item_valid && !item_stall) begin
        hit = -1;
        for (i = 0; i < distinct_n; i++)
          if (hit < 0 && seen_value[i] == value) hit = i;
        if (hit >= 0) begin
          if (seen_count[hit] != '1) seen_count[hit] = seen_count[hit] + 1'b1;
        end else if (distinct_n < dvc_pkg::TABLE_DEPTH) begin
          seen_value[distinct_n] = value;
          seen_count[distinct_n] = dvc_pkg::COUNT_BITS'(1);
          distinct_n++;
        end else begin
          // table full: drop the new value
          spilled = 1'b1;
        end

        if (last) begin
          best    = '0;
          dup_sum = 0;
          want    = '0;
          // strictly greater keeps the earliest entry on ties
          for (i = 0; i < distinct_n; i++) begin
            if (seen_count[i] > best) begin
              best     = seen_count[i];
              want.top = seen_value[i];
            end
            dup_sum += seen_count[i] - 1'b1;
          end
          top_dup    = (best == 0) ? 0 : longint'(best) - 1;
          want.dups  = dvc_pkg::OUT_BITS'((top_dup > OUT_MAX) ? OUT_MAX : top_dup);
          want.total = dvc_pkg::OUT_BITS'((dup_sum > OUT_MAX) ? OUT_MAX : dup_sum);
          want.spill = spilled;
          predicted_summaries.push_back(want);
          distinct_n = 0;
          spilled    = 1'b0;
        end
      end
    end
  end

endmodule

### test/duplicate_value_counter_unit_tb.sv
`timescale 1ns / 1ps

module duplicate_value_counter_unit_tb;

  localparam int RANDOM_ITEMS   = 800;
  localparam int QUIET_TAIL     = 150;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 600;

  logic                                  clk = 1'b0;
  logic                                  rst = 1'b1;
  logic signed [dvc_pkg::VALUE_BITS-1:0] value = '0;
  logic                                  last = 1'b0;
  logic                                  item_valid = 1'b0;
  logic                                  item_stall;
  logic signed [dvc_pkg::VALUE_BITS-1:0] top_value;
  logic [dvc_pkg::OUT_BITS-1:0]          top_duplicates;
  logic [dvc_pkg::OUT_BITS-1:0]          total_duplicates;
  logic                                  overflow;
  logic                                  result_valid;
  logic                                  result_stall = 1'b0;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned sets_checked;

  logic        quiet = 1'b0;
  int unsigned gap_pct = 0;
  int unsigned items_sent = 0;
  int unsigned random_sets = 0;
  int unsigned idle_cycles = 0;

  logic [31:0] batch [$];
  logic [31:0] pool [6];

  always #4 clk = ~clk;

  duplicate_value_counter_unit i_dut (
    .clk              (clk),
    .rst              (rst),
    .value            (value),
    .last             (last),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .top_value        (top_value),
    .top_duplicates   (top_duplicates),
    .total_duplicates (total_duplicates),
    .overflow         (overflow),
    .result_valid     (result_valid),
    .result_stall     (result_stall)
  );

  duplicate_tally_checker i_checker (
    .clk              (clk),
    .rst              (rst),
    .value            (value),
    .last             (last),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .top_value        (top_value),
    .top_duplicates   (top_duplicates),
    .total_duplicates (total_duplicates),
    .overflow         (overflow),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .mismatches       (mismatches),
    .outstanding      (outstanding),
    .sets_checked     (sets_checked)
  );

  // result side back-pressure: random bursts, odds change by phase
  always @(posedge clk) begin : stall_gen
    int unsigned hold_left;
    int unsigned stall_pct;
    int unsigned phase_left;
    if (rst || quiet) begin
      result_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (phase_left == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 15;
          default: stall_pct = 50;
        endcase
        phase_left = $urandom_range(200, 600);
      end else begin
        phase_left--;
      end
      if (hold_left != 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        result_stall <= 1'b1;
        hold_left = $urandom_range(0, 13);
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, outstanding);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // hold the transaction until accepted, then maybe idle the sender
  task automatic send_value(input logic [31:0] v, input logic is_last);
    value      <= v;
    last       <= is_last;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
    if (!quiet && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic send_batch();
    int i;
    for (i = 0; i < batch.size(); i++) send_value(batch[i], i == batch.size() - 1);
  endtask

  // fill every table entry; extra_new new values are dropped after that
  task automatic send_full_set(input int extra_new, input logic finish_new);
    logic [31:0] vals [dvc_pkg::TABLE_DEPTH];
    logic [31:0] v;
    int          i;
    for (i = 0; i < dvc_pkg::TABLE_DEPTH; i++) begin
      v        = $urandom;
      v[31:24] = i[7:0];
      v[0]     = 1'b0;
      vals[i]  = v;
      send_value(v, extra_new == 0 && i == dvc_pkg::TABLE_DEPTH - 1);
      if (i % 8 == 3) send_value(vals[$urandom_range(0, i)], 1'b0);
    end
    if (extra_new > 0) begin
      // odd values never match a stored (even) one
      for (i = 0; i < extra_new; i++) begin
        send_value($urandom | 32'h1, 1'b0);
        send_value(vals[$urandom_range(0, dvc_pkg::TABLE_DEPTH - 1)], 1'b0);
      end
      send_value(finish_new ? ($urandom | 32'h1) : vals[0], 1'b1);
    end
  endtask

  initial begin : stimulus
    int unsigned rand_start;
    int unsigned set_len;
    int unsigned pool_n;
    int          k;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    gap_pct = 20;
    batch = '{32'h8000_0000};
    send_batch();
    batch = '{32'h7fff_ffff};
    send_batch();
    batch = '{32'h0, 32'hffff_ffff, 32'h0, 32'hffff_ffff, 32'hffff_ffff};
    send_batch();
    // tie on count: the earlier value wins
    batch = '{32'd5, 32'd7, 32'd7, 32'd5, 32'd9};
    send_batch();
    batch = '{32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa};
    send_batch();
    batch = '{32'd1, 32'd2, 32'd3};
    send_batch();

    gap_pct = 5;
    send_full_set(0, 1'b0);
    send_full_set(3, 1'b1);
    send_full_set(1, 1'b0);

    rand_start = items_sent;
    while (items_sent - rand_start < RANDOM_ITEMS) begin
      if (items_sent - rand_start >= RANDOM_ITEMS - QUIET_TAIL) quiet <= 1'b1;
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 10;
        default: gap_pct = 40;
      endcase
      set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      pool_n  = $urandom_range(1, 6);
      for (k = 0; k < pool_n; k++) begin
        case ($urandom_range(0, 7))
          0:       pool[k] = 32'h8000_0000;
          1:       pool[k] = 32'h7fff_ffff;
          2:       pool[k] = 32'h0;
          3:       pool[k] = 32'hffff_ffff;
          default: pool[k] = $urandom;
        endcase
      end
      batch.delete();
      for (k = 0; k < set_len; k++)
        batch.push_back(($urandom_range(0, 4) == 0) ? $urandom : pool[$urandom_range(0, pool_n - 1)]);
      send_batch();
      random_sets++;
    end
    item_valid <= 1'b0;

    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);

    $display("Checked %0d results over %0d values: directed sets, full tables with and without",
             sets_checked, items_sent);
    $display("dropped values, and %0d random sets under back-pressure.",
             random_sets);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
